// File: hw/rtl/mlqs_pkg.sv
// Shared constants and item layouts for the multilevel queue scheduler.
package mlqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 8;
    localparam int PRIO_W      = 8;
    localparam int TIME_W      = 24;
    localparam int BURST_W     = 16;
    localparam int SLICE_W     = 2;

    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  arr;
        logic [BURST_W-1:0] rem;
    } t_pend;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] rem;
    } t_proc;

    localparam int PEND_W = $bits(t_pend);
    localparam int PROC_W = $bits(t_proc);

endpackage

// File: hw/rtl/multilevel_queue_scheduler.sv
// Top level of the two-level scheduler: control sequencer around three queue RAMs.
// An admit item passes through the DONE state and then returns to IDLE, where the next item is taken.
// A step item moves arrived items from pending to ready, selects the best ready process and runs it,
// scanning the pending and ready RAMs one entry a cycle, so its work grows with their occupancies.
// Synchronous active-low reset clears counters, pointers, time and the running process;
// the RAM contents are left as they are, as no entry is read before it is written.
module multilevel_queue_scheduler #(
    parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_func,
    input  logic [mlqs_pkg::ID_W-1:0]      i_proc_id,
    input  logic [mlqs_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [mlqs_pkg::TIME_W-1:0]    i_arrival_time,
    input  logic [mlqs_pkg::BURST_W-1:0]   i_burst,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_status,
    output logic [mlqs_pkg::ID_W-1:0]      o_running_id,
    output logic [mlqs_pkg::TIME_W-1:0]    o_start_time,
    output logic [mlqs_pkg::SLICE_W-1:0]   o_slice_ticks,
    output logic                           o_finished,
    output logic [mlqs_pkg::ID_W-1:0]      o_finished_id,
    output logic [mlqs_pkg::TIME_W-1:0]    o_now
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_MV_CHK  = 15'b000000000000010,
        S_MV_SCAN = 15'b000000000000100,
        S_MV_DEC  = 15'b000000000001000,
        S_MV_SHR  = 15'b000000000010000,
        S_MV_SHW  = 15'b000000000100000,
        S_RQ_CHK  = 15'b000000001000000,
        S_RQ_SCAN = 15'b000000010000000,
        S_DECIDE  = 15'b000000100000000,
        S_RS_SHR  = 15'b000001000000000,
        S_RS_SHW  = 15'b000010000000000,
        S_EXEC    = 15'b000100000000000,
        S_POPA    = 15'b001000000000000,
        S_POPD    = 15'b010000000000000,
        S_DONE    = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_pend_cnt, n_pend_cnt;
    logic [CW-1:0] r_ready_cnt, n_ready_cnt;
    logic [CW-1:0] r_rr_cnt, n_rr_cnt;
    logic [IW-1:0] r_rr_head, n_rr_head;
    logic [IW-1:0] r_scan, n_scan;
    logic [IW-1:0] r_sh, n_sh;
    logic          r_take2, n_take2;

    mlqs_pkg::t_proc               r_cur, n_cur;
    logic                          r_idle, n_idle;
    logic                          r_low, n_low;
    logic [mlqs_pkg::TIME_W-1:0]   r_now, n_now;

    mlqs_pkg::t_pend r_best, n_best;
    logic [IW-1:0]   r_best_idx, n_best_idx;

    logic                           r_res_status, n_res_status;
    logic [mlqs_pkg::ID_W-1:0]      r_res_run, n_res_run;
    logic [mlqs_pkg::TIME_W-1:0]    r_res_start, n_res_start;
    logic [mlqs_pkg::SLICE_W-1:0]   r_res_slice, n_res_slice;
    logic                           r_res_fin, n_res_fin;
    logic [mlqs_pkg::ID_W-1:0]      r_res_finid, n_res_finid;

    logic                           r_o_valid, n_o_valid;
    logic                           r_o_status, n_o_status;
    logic [mlqs_pkg::ID_W-1:0]      r_o_run, n_o_run;
    logic [mlqs_pkg::TIME_W-1:0]    r_o_start, n_o_start;
    logic [mlqs_pkg::SLICE_W-1:0]   r_o_slice, n_o_slice;
    logic                           r_o_fin, n_o_fin;
    logic [mlqs_pkg::ID_W-1:0]      r_o_finid, n_o_finid;
    logic [mlqs_pkg::TIME_W-1:0]    r_o_now, n_o_now;

    logic                          pend_we, ready_we, rr_we;
    logic [IW-1:0]                 pend_waddr, pend_raddr, ready_waddr, ready_raddr;
    logic [IW-1:0]                 rr_waddr, rr_raddr;
    logic [mlqs_pkg::PEND_W-1:0]   pend_wdata, pend_rdata;
    logic [mlqs_pkg::PROC_W-1:0]   ready_wdata, ready_rdata, rr_wdata, rr_rdata;
    mlqs_pkg::t_pend               pend_rd;
    mlqs_pkg::t_proc               ready_rd, rr_rd;

    logic [IW:0]                   rr_sum;
    logic [IW-1:0]                 rr_tail, rr_head_inc;
    logic [CW+1:0]                 resident;
    logic [mlqs_pkg::SLICE_W-1:0]  lim, slice;
    logic [mlqs_pkg::BURST_W-1:0]  rem_new;
    mlqs_pkg::t_proc               cur_upd;

    assign pend_rd  = pend_rdata;
    assign ready_rd = ready_rdata;
    assign rr_rd    = rr_rdata;

    mlqs_ram #(.WIDTH(mlqs_pkg::PEND_W), .DEPTH(QUEUE_DEPTH)) u_pend_ram (
        .i_clk(i_clk), .i_we(pend_we), .i_waddr(pend_waddr), .i_wdata(pend_wdata),
        .i_raddr(pend_raddr), .o_rdata(pend_rdata)
    );

    mlqs_ram #(.WIDTH(mlqs_pkg::PROC_W), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
        .i_clk(i_clk), .i_we(ready_we), .i_waddr(ready_waddr), .i_wdata(ready_wdata),
        .i_raddr(ready_raddr), .o_rdata(ready_rdata)
    );

    mlqs_ram #(.WIDTH(mlqs_pkg::PROC_W), .DEPTH(QUEUE_DEPTH)) u_rr_ram (
        .i_clk(i_clk), .i_we(rr_we), .i_waddr(rr_waddr), .i_wdata(rr_wdata),
        .i_raddr(rr_raddr), .o_rdata(rr_rdata)
    );

    assign rr_sum      = (IW+1)'(r_rr_head) + (IW+1)'(r_rr_cnt);
    assign rr_tail     = (rr_sum >= (IW+1)'(QUEUE_DEPTH)) ?
                         IW'(rr_sum - (IW+1)'(QUEUE_DEPTH)) : IW'(rr_sum);
    assign rr_head_inc = (r_rr_head == IW'(QUEUE_DEPTH - 1)) ? '0 : r_rr_head + IW'(1);
    assign resident    = (CW+2)'(r_pend_cnt) + (CW+2)'(r_ready_cnt) + (CW+2)'(r_rr_cnt)
                         + (CW+2)'(!r_idle);
    assign lim         = r_low ? mlqs_pkg::SLICE_W'(2) : mlqs_pkg::SLICE_W'(1);
    assign slice       = (r_cur.rem < mlqs_pkg::BURST_W'(lim)) ?
                         r_cur.rem[mlqs_pkg::SLICE_W-1:0] : lim;
    assign rem_new     = r_cur.rem - mlqs_pkg::BURST_W'(slice);

    always_comb begin
        cur_upd     = r_cur;
        cur_upd.rem = rem_new;
    end

    always_comb begin
        n_state      = r_state;
        n_pend_cnt   = r_pend_cnt;
        n_ready_cnt  = r_ready_cnt;
        n_rr_cnt     = r_rr_cnt;
        n_rr_head    = r_rr_head;
        n_scan       = r_scan;
        n_sh         = r_sh;
        n_take2      = r_take2;
        n_cur        = r_cur;
        n_idle       = r_idle;
        n_low        = r_low;
        n_now        = r_now;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_res_status = r_res_status;
        n_res_run    = r_res_run;
        n_res_start  = r_res_start;
        n_res_slice  = r_res_slice;
        n_res_fin    = r_res_fin;
        n_res_finid  = r_res_finid;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_run      = r_o_run;
        n_o_start    = r_o_start;
        n_o_slice    = r_o_slice;
        n_o_fin      = r_o_fin;
        n_o_finid    = r_o_finid;
        n_o_now      = r_o_now;

        pend_we     = 1'b0;
        pend_waddr  = r_pend_cnt[IW-1:0];
        pend_wdata  = {i_proc_id, i_priority_req, i_arrival_time, i_burst};
        pend_raddr  = r_scan + IW'(1);
        ready_we    = 1'b0;
        ready_waddr = r_ready_cnt[IW-1:0];
        ready_wdata = {r_best.id, r_best.prio, r_best.rem};
        ready_raddr = r_scan + IW'(1);
        rr_we       = 1'b0;
        rr_waddr    = rr_tail;
        rr_wdata    = r_cur;
        rr_raddr    = r_rr_head;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == mlqs_pkg::FUNC_ADMIT) begin
                        n_res_status = (resident >= (CW+2)'(QUEUE_DEPTH));
                        if (resident < (CW+2)'(QUEUE_DEPTH)) begin
                            pend_we    = 1'b1;
                            n_pend_cnt = r_pend_cnt + CW'(1);
                        end
                        n_res_run   = '0;
                        n_res_start = r_now;
                        n_res_slice = '0;
                        n_res_fin   = 1'b0;
                        n_res_finid = '0;
                        n_state     = S_DONE;
                    end else begin
                        n_res_status = 1'b0;
                        n_take2      = 1'b0;
                        n_state      = S_MV_CHK;
                    end
                end
            end
            S_MV_CHK: begin
                pend_raddr = '0;
                n_scan     = '0;
                if (r_pend_cnt != '0 && r_ready_cnt < CW'(QUEUE_DEPTH)) begin
                    n_state = S_MV_SCAN;
                end else begin
                    n_state = S_RQ_CHK;
                end
            end
            S_MV_SCAN: begin
                if (r_scan == '0 || pend_rd.arr < r_best.arr) begin
                    n_best     = pend_rd;
                    n_best_idx = r_scan;
                end
                if (CW'(r_scan) + CW'(1) == r_pend_cnt) begin
                    n_state = S_MV_DEC;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            S_MV_DEC: begin
                if (r_best.arr > r_now) begin
                    n_state = S_RQ_CHK;
                end else begin
                    ready_we    = 1'b1;
                    n_ready_cnt = r_ready_cnt + CW'(1);
                    n_pend_cnt  = r_pend_cnt - CW'(1);
                    n_sh        = r_best_idx;
                    if (CW'(r_best_idx) < r_pend_cnt - CW'(1)) begin
                        n_state = S_MV_SHR;
                    end else begin
                        n_state = S_MV_CHK;
                    end
                end
            end
            S_MV_SHR: begin
                pend_raddr = r_sh + IW'(1);
                n_state    = S_MV_SHW;
            end
            S_MV_SHW: begin
                pend_we    = 1'b1;
                pend_waddr = r_sh;
                pend_wdata = pend_rdata;
                n_sh       = r_sh + IW'(1);
                if ((CW+1)'(r_sh) + (CW+1)'(2) <= (CW+1)'(r_pend_cnt)) begin
                    n_state = S_MV_SHR;
                end else begin
                    n_state = S_MV_CHK;
                end
            end
            S_RQ_CHK: begin
                ready_raddr = '0;
                n_scan      = '0;
                if (r_ready_cnt != '0) begin
                    n_state = S_RQ_SCAN;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_RQ_SCAN: begin
                if (r_scan == '0 || ready_rd.prio < r_best.prio) begin
                    n_best.id   = ready_rd.id;
                    n_best.prio = ready_rd.prio;
                    n_best.rem  = ready_rd.rem;
                    n_best_idx  = r_scan;
                end
                if (CW'(r_scan) + CW'(1) == r_ready_cnt) begin
                    n_state = S_DECIDE;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            S_DECIDE: begin
                if (r_take2 || r_idle || r_cur.prio > r_best.prio) begin
                    if (!r_take2 && !r_idle && r_rr_cnt < CW'(QUEUE_DEPTH)) begin
                        rr_we    = 1'b1;
                        n_rr_cnt = r_rr_cnt + CW'(1);
                    end
                    n_cur.id    = r_best.id;
                    n_cur.prio  = r_best.prio;
                    n_cur.rem   = r_best.rem;
                    n_idle      = 1'b0;
                    n_low       = 1'b0;
                    n_ready_cnt = r_ready_cnt - CW'(1);
                    n_sh        = r_best_idx;
                    if (CW'(r_best_idx) < r_ready_cnt - CW'(1)) begin
                        n_state = S_RS_SHR;
                    end else if (r_take2) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_EXEC;
                    end
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_RS_SHR: begin
                ready_raddr = r_sh + IW'(1);
                n_state     = S_RS_SHW;
            end
            S_RS_SHW: begin
                ready_we    = 1'b1;
                ready_waddr = r_sh;
                ready_wdata = ready_rdata;
                n_sh        = r_sh + IW'(1);
                if ((CW+1)'(r_sh) + (CW+1)'(2) <= (CW+1)'(r_ready_cnt)) begin
                    n_state = S_RS_SHR;
                end else if (r_take2) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_start = r_now;
                if (r_idle) begin
                    n_res_slice = mlqs_pkg::SLICE_W'(1);
                    n_res_run   = '0;
                    n_res_fin   = 1'b0;
                    n_res_finid = '0;
                    n_now       = r_now + mlqs_pkg::TIME_W'(1);
                    n_state     = S_DONE;
                end else begin
                    n_res_slice = slice;
                    n_res_run   = r_cur.id;
                    n_now       = r_now + mlqs_pkg::TIME_W'(slice);
                    n_cur       = cur_upd;
                    if (rem_new == '0) begin
                        n_res_fin   = 1'b1;
                        n_res_finid = r_cur.id;
                        n_cur       = '0;
                        if (r_ready_cnt != '0) begin
                            n_take2 = 1'b1;
                            n_state = S_RQ_CHK;
                        end else if (r_rr_cnt != '0) begin
                            n_low   = 1'b1;
                            n_state = S_POPA;
                        end else begin
                            n_idle  = 1'b1;
                            n_low   = 1'b0;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_res_fin   = 1'b0;
                        n_res_finid = '0;
                        if (r_low) begin
                            if (r_rr_cnt < CW'(QUEUE_DEPTH)) begin
                                rr_we    = 1'b1;
                                rr_wdata = cur_upd;
                                n_rr_cnt = r_rr_cnt + CW'(1);
                            end
                            n_state = S_POPA;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_POPA: begin
                n_state = S_POPD;
            end
            S_POPD: begin
                n_cur     = rr_rd;
                n_rr_head = rr_head_inc;
                n_rr_cnt  = r_rr_cnt - CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_run    = r_res_run;
                    n_o_start  = r_res_start;
                    n_o_slice  = r_res_slice;
                    n_o_fin    = r_res_fin;
                    n_o_finid  = r_res_finid;
                    n_o_now    = r_now;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_cnt  <= '0;
            r_ready_cnt <= '0;
            r_rr_cnt    <= '0;
            r_rr_head   <= '0;
            r_take2     <= 1'b0;
            r_cur       <= '0;
            r_idle      <= 1'b1;
            r_low       <= 1'b0;
            r_now       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_cnt  <= n_pend_cnt;
            r_ready_cnt <= n_ready_cnt;
            r_rr_cnt    <= n_rr_cnt;
            r_rr_head   <= n_rr_head;
            r_take2     <= n_take2;
            r_cur       <= n_cur;
            r_idle      <= n_idle;
            r_low       <= n_low;
            r_now       <= n_now;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_sh         <= n_sh;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_res_status <= n_res_status;
        r_res_run    <= n_res_run;
        r_res_start  <= n_res_start;
        r_res_slice  <= n_res_slice;
        r_res_fin    <= n_res_fin;
        r_res_finid  <= n_res_finid;
        r_o_status   <= n_o_status;
        r_o_run      <= n_o_run;
        r_o_start    <= n_o_start;
        r_o_slice    <= n_o_slice;
        r_o_fin      <= n_o_fin;
        r_o_finid    <= n_o_finid;
        r_o_now      <= n_o_now;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_running_id  = r_o_run;
    assign o_start_time  = r_o_start;
    assign o_slice_ticks = r_o_slice;
    assign o_finished    = r_o_fin;
    assign o_finished_id = r_o_finid;
    assign o_now         = r_o_now;

endmodule

// File: hw/rtl/mlqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mlqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mlqs_checker.sv
// Port-level checker for the multilevel queue scheduler, bound to the top level.
module mlqs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_status,
    input logic [mlqs_pkg::ID_W-1:0]      o_running_id,
    input logic [mlqs_pkg::TIME_W-1:0]    o_start_time,
    input logic [mlqs_pkg::SLICE_W-1:0]   o_slice_ticks,
    input logic                           o_finished,
    input logic [mlqs_pkg::ID_W-1:0]      o_finished_id,
    input logic [mlqs_pkg::TIME_W-1:0]    o_now
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_now) && $stable(o_running_id))
        else $error("Result item changed while stalled.");

    a_slice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_slice_ticks != 2'd3)
        else $error("Slice exceeds two ticks.");

    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_slice_ticks == '0 && o_running_id == '0 && !o_finished
        && o_start_time == o_now)
        else $error("Rejected admit reports activity.");

    a_finish_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> o_finished_id == o_running_id)
        else $error("Finished identifier differs from the running process.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid straight after reset.");

endmodule

bind multilevel_queue_scheduler mlqs_checker u_mlqs_checker (.*);

// File: bench/tb_multilevel_queue_scheduler.sv
// Self-checking testbench for the two-level multilevel queue scheduler.
module tb_multilevel_queue_scheduler;

    typedef struct packed {
        logic                         status;
        logic [mlqs_pkg::ID_W-1:0]    run_id;
        logic [mlqs_pkg::TIME_W-1:0]  start;
        logic [mlqs_pkg::SLICE_W-1:0] slice;
        logic                         fin;
        logic [mlqs_pkg::ID_W-1:0]    fin_id;
        logic [mlqs_pkg::TIME_W-1:0]  now_t;
    } t_sched_res;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic                           i_func;
    logic [mlqs_pkg::ID_W-1:0]      i_proc_id;
    logic [mlqs_pkg::PRIO_W-1:0]    i_priority_req;
    logic [mlqs_pkg::TIME_W-1:0]    i_arrival_time;
    logic [mlqs_pkg::BURST_W-1:0]   i_burst;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_status;
    logic [mlqs_pkg::ID_W-1:0]      o_running_id;
    logic [mlqs_pkg::TIME_W-1:0]    o_start_time;
    logic [mlqs_pkg::SLICE_W-1:0]   o_slice_ticks;
    logic                           o_finished;
    logic [mlqs_pkg::ID_W-1:0]      o_finished_id;
    logic [mlqs_pkg::TIME_W-1:0]    o_now;

    multilevel_queue_scheduler dut (.*);

    // Scheduler shadow state.
    mlqs_pkg::t_pend             pend_store [mlqs_pkg::QUEUE_DEPTH];
    mlqs_pkg::t_pend             ready_list [mlqs_pkg::QUEUE_DEPTH];
    mlqs_pkg::t_pend             rr_ring    [mlqs_pkg::QUEUE_DEPTH];
    int                          pend_n, ready_n, rr_head, rr_n;
    mlqs_pkg::t_pend             cur_proc;
    bit                          cpu_idle;
    bit                          low_level;
    logic [mlqs_pkg::TIME_W-1:0] tick;

    t_sched_res        sched_expected [$];
    int                mismatches;
    bit                bus_held;
    bit                quiet;
    int                rx_stall;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic int resident();
        return pend_n + ready_n + rr_n + (cpu_idle ? 0 : 1);
    endfunction

    function automatic int ready_best();
        int best;
        best = 0;
        for (int i = 1; i < ready_n; i++)
            if (ready_list[i].prio < ready_list[best].prio) best = i;
        return best;
    endfunction

    function automatic mlqs_pkg::t_pend ready_pull();
        mlqs_pkg::t_pend p;
        int k;
        k = ready_best();
        p = ready_list[k];
        for (int i = k; i + 1 < ready_n; i++) ready_list[i] = ready_list[i + 1];
        ready_n--;
        return p;
    endfunction

    function automatic void rr_put(mlqs_pkg::t_pend p);
        if (rr_n < mlqs_pkg::QUEUE_DEPTH) begin
            rr_ring[(rr_head + rr_n) % mlqs_pkg::QUEUE_DEPTH] = p;
            rr_n++;
        end
    endfunction

    function automatic mlqs_pkg::t_pend rr_take();
        mlqs_pkg::t_pend p;
        p = rr_ring[rr_head];
        rr_head = (rr_head + 1) % mlqs_pkg::QUEUE_DEPTH;
        rr_n--;
        return p;
    endfunction

    function automatic void admit_arrivals();
        int best;
        while (pend_n > 0 && ready_n < mlqs_pkg::QUEUE_DEPTH) begin
            best = 0;
            for (int i = 1; i < pend_n; i++)
                if (pend_store[i].arr < pend_store[best].arr) best = i;
            if (pend_store[best].arr > tick) break;
            ready_list[ready_n++] = pend_store[best];
            for (int i = best; i + 1 < pend_n; i++) pend_store[i] = pend_store[i + 1];
            pend_n--;
        end
    endfunction

    function automatic t_sched_res schedule_item(logic func, logic [mlqs_pkg::ID_W-1:0] id,
            logic [mlqs_pkg::PRIO_W-1:0] prio, logic [mlqs_pkg::TIME_W-1:0] arr,
            logic [mlqs_pkg::BURST_W-1:0] burst);
        t_sched_res r;
        mlqs_pkg::t_pend p;
        logic [mlqs_pkg::SLICE_W-1:0] lim;
        r = '0;
        r.start = tick;
        if (func == mlqs_pkg::FUNC_ADMIT) begin
            if (resident() >= mlqs_pkg::QUEUE_DEPTH) begin
                r.status = 1'b1;
            end else begin
                p.id = id;
                p.prio = prio;
                p.arr = arr;
                p.rem = burst;
                pend_store[pend_n++] = p;
            end
        end else begin
            admit_arrivals();
            if (ready_n > 0) begin
                if (cpu_idle) begin
                    cpu_idle = 1'b0;
                    low_level = 1'b0;
                    cur_proc = ready_pull();
                end else if (cur_proc.prio > ready_list[ready_best()].prio) begin
                    low_level = 1'b0;
                    rr_put(cur_proc);
                    cur_proc = ready_pull();
                end
            end
            r.start = tick;
            if (cpu_idle) begin
                r.slice = 2'd1;
                tick = tick + 24'd1;
            end else begin
                lim = low_level ? 2'd2 : 2'd1;
                r.slice = (cur_proc.rem < 16'(lim)) ? cur_proc.rem[1:0] : lim;
                cur_proc.rem = cur_proc.rem - 16'(r.slice);
                tick = tick + 24'(r.slice);
                r.run_id = cur_proc.id;
                if (cur_proc.rem == 0) begin
                    r.fin = 1'b1;
                    r.fin_id = cur_proc.id;
                    cur_proc = '0;
                    if (ready_n > 0) begin
                        low_level = 1'b0;
                        cur_proc = ready_pull();
                    end else if (rr_n > 0) begin
                        low_level = 1'b1;
                        cur_proc = rr_take();
                    end else begin
                        cpu_idle = 1'b1;
                        low_level = 1'b0;
                    end
                end else if (low_level) begin
                    rr_put(cur_proc);
                    cur_proc = rr_take();
                end
            end
        end
        r.now_t = tick;
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_item(logic func, logic [mlqs_pkg::ID_W-1:0] id,
            logic [mlqs_pkg::PRIO_W-1:0] prio, logic [mlqs_pkg::TIME_W-1:0] arr,
            logic [mlqs_pkg::BURST_W-1:0] burst);
        int gap;
        i_valid        <= 1'b1;
        i_func         <= func;
        i_proc_id      <= id;
        i_priority_req <= prio;
        i_arrival_time <= arr;
        i_burst        <= burst;
        bus_held = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sched_expected.push_back(schedule_item(func, id, prio, arr, burst));
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            bus_held = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic admit(logic [mlqs_pkg::ID_W-1:0] id, logic [mlqs_pkg::PRIO_W-1:0] prio,
            logic [mlqs_pkg::TIME_W-1:0] arr, logic [mlqs_pkg::BURST_W-1:0] burst);
        send_item(mlqs_pkg::FUNC_ADMIT, id, prio, arr, burst);
    endtask

    task automatic step();
        send_item(mlqs_pkg::FUNC_STEP, 8'($urandom), 8'($urandom), 24'($urandom),
                  16'($urandom));
    endtask

    task automatic drain();
        if (bus_held) begin
            i_valid <= 1'b0;
            bus_held = 1'b0;
        end
        while (sched_expected.size() != 0) @(negedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got);
        if (exp_v !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sched_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (sched_expected.size() == 0) begin
                $display("%0t: unexpected item, expected none actual running_id %0h",
                         $time, o_running_id);
                mismatches++;
            end else begin
                e = sched_expected.pop_front();
                check_field("status", 32'(e.status), 32'(o_status));
                check_field("running_id", 32'(e.run_id), 32'(o_running_id));
                check_field("start_time", 32'(e.start), 32'(o_start_time));
                check_field("slice_ticks", 32'(e.slice), 32'(o_slice_ticks));
                check_field("finished", 32'(e.fin), 32'(o_finished));
                check_field("finished_id", 32'(e.fin_id), 32'(o_finished_id));
                check_field("now", 32'(e.now_t), 32'(o_now));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_stall <= 0;
        end else if (rx_stall > 0) begin
            i_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            i_ready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    task automatic test_idle_steps();
        repeat (3) step();
    endtask

    task automatic test_field_extremes();
        admit(8'd0, 8'd0, tick, 16'd1);
        admit(8'hFF, 8'hFF, tick, 16'd0);
        admit(8'h5A, 8'h80, tick + 24'd1, 16'd2);
        repeat (6) step();
    endtask

    task automatic test_preemption();
        admit(8'h11, 8'd200, tick, 16'd5);
        step();
        admit(8'h22, 8'd3, tick, 16'd2);
        admit(8'h33, 8'd100, tick + 24'd1, 16'd3);
        repeat (8) step();
    endtask

    task automatic test_ties();
        admit(8'h41, 8'd7, tick + 24'd2, 16'd1);
        admit(8'h42, 8'd7, tick + 24'd2, 16'd1);
        admit(8'h43, 8'd7, tick + 24'd1, 16'd0);
        repeat (6) step();
        drain();
    endtask

    task automatic test_random_traffic(int n);
        int k, choice;
        logic [mlqs_pkg::BURST_W-1:0] b;
        logic [mlqs_pkg::PRIO_W-1:0] p;
        for (k = 0; k < n; k++) begin
            if (k % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (k == n / 2) begin
                quiet = 1'b0;
                drain();
            end
            choice = $urandom_range(0, 99);
            if (choice < 40 && resident() < mlqs_pkg::QUEUE_DEPTH - 1 || choice < 3) begin
                choice = $urandom_range(0, 9);
                b = (choice == 0) ? 16'd0 : (choice < 8) ? 16'($urandom_range(1, 6))
                                                        : 16'($urandom_range(7, 40));
                p = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                admit(8'($urandom), p, tick + 24'($urandom_range(0, 8)), b);
            end else begin
                step();
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_store_full();
        int k;
        for (k = 0; k < mlqs_pkg::QUEUE_DEPTH + 2; k++)
            admit(8'($urandom), 8'($urandom),
                  (k == 0) ? 24'hFFFFFF : 24'($urandom_range(24'h800000, 24'hFFFFFF)),
                  (k == 0) ? 16'hFFFF : 16'($urandom));
        step();
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = mlqs_pkg::FUNC_ADMIT;
        i_proc_id = '0;
        i_priority_req = '0;
        i_arrival_time = '0;
        i_burst = '0;
        mismatches = 0;
        bus_held = 1'b0;
        quiet = 1'b0;
        pend_n = 0;
        ready_n = 0;
        rr_head = 0;
        rr_n = 0;
        cur_proc = '0;
        cpu_idle = 1'b1;
        low_level = 1'b0;
        tick = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_steps();
        test_field_extremes();
        test_preemption();
        test_ties();
        test_random_traffic(1800);
        test_store_full();

        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
